>>> rtl/core/fssm_pkg.sv
// Package for the four-servo smoothstep mover: sizes, fixed-point reciprocals,
// register indexes, sequencer states and the control bundle.
// Has no dependencies; every other file of the block uses it.
`default_nettype none

package fssm_pkg;

	// Move shape and servo geometry
	localparam int STEP_COUNT  = 20;
	localparam int STEP_W      = $clog2(STEP_COUNT + 1);
	localparam int LEG_COUNT   = 4;
	localparam int LEG_W       = $clog2(LEG_COUNT);
	localparam int ANGLE_W     = 8;
	localparam int ANGLE_MAX   = 180;
	localparam int ANGLE_RESET = 90;
	localparam int ANG_S_W     = ANGLE_W + 3;

	// Legs whose servo sees the mirrored angle
	localparam logic [LEG_W-1:0] LEG_FR = 2'd1;
	localparam logic [LEG_W-1:0] LEG_BL = 2'd2;

	// Pulse, duty and timing
	localparam int PERIOD_US   = 20000;
	localparam int DUTY_FULL   = 16383;
	localparam int DUTY_W      = 14;
	localparam int PULSE_W     = 15;
	localparam int PULSE_S_W   = PULSE_W + 3;
	localparam int MS_W        = 16;
	localparam int HOLD_W      = 12;
	localparam int MIN_RESET   = 500;
	localparam int MAX_RESET   = 2500;

	// Configuration port
	localparam int CFG_W     = 15;
	localparam int CFG_IDX_W = 1;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_MIN_PULSE = 1'b0;
	localparam cfg_idx_t CFG_MAX_PULSE = 1'b1;

	// Smoothstep numerator i*i*(3S-2i) and its denominator S^3
	localparam int NUM_DEN = STEP_COUNT * STEP_COUNT * STEP_COUNT;
	localparam int SQ_W    = 2 * STEP_W;
	localparam int NUM_W   = $clog2(NUM_DEN + 1);
	localparam int MAG_W   = ANGLE_W + NUM_W;
	localparam int SCALED_W = ANGLE_W + PULSE_W;

	// Shared multiplier operand widths
	localparam int MUL_A_W = 24;
	localparam int MUL_B_W = 30;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// Rounded-up reciprocals; each is exact over the range of its dividend.
	localparam int DEN_SHIFT  = 34;
	localparam longint RECIP_DEN =
		((longint'(1) << DEN_SHIFT) + NUM_DEN - 1) / NUM_DEN;
	localparam int ANG_SHIFT  = 31;
	localparam longint RECIP_ANG =
		((longint'(1) << ANG_SHIFT) + ANGLE_MAX - 1) / ANGLE_MAX;
	localparam int DUTY_SHIFT = 30;
	localparam longint RECIP_DUTY =
		((longint'(DUTY_FULL) << DUTY_SHIFT) + PERIOD_US - 1) / PERIOD_US;
	localparam int HOLD_SHIFT = 20;
	localparam longint RECIP_HOLD =
		((longint'(1) << HOLD_SHIFT) + STEP_COUNT - 1) / STEP_COUNT;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_HOLD_CAP,
		ST_SQ_MUL,
		ST_NUM_MUL,
		ST_NUM_CAP,
		ST_DEL_MUL,
		ST_DEN_MUL,
		ST_ANG,
		ST_SPAN_MUL,
		ST_DIV_MUL,
		ST_PULSE,
		ST_DUTY_MUL,
		ST_DUTY,
		ST_LOAD
	} state_t;

	// Control bundle from the sequencer to the datapath
	typedef struct packed {
		state_t              st;
		logic [STEP_W-1:0]   step;
		logic [LEG_W-1:0]    leg;
		logic                load;
		logic                finish;
	} ctrl_t;

endpackage

`default_nettype wire

>>> rtl/core/fssm_mul.sv
// Shared unsigned multiplier of the servo mover with a registered product.
// Uses fssm_pkg for operand widths.
`default_nettype none

module fssm_mul (
	input  logic                             clk,
	input  logic [fssm_pkg::MUL_A_W-1:0]     a,
	input  logic [fssm_pkg::MUL_B_W-1:0]     b,
	output logic [fssm_pkg::MUL_P_W-1:0]     prod_q
);

	// Every product of the block passes through this one register.
	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

endmodule

`default_nettype wire

>>> rtl/core/fssm_ctrl.sv
// Sequencer of the servo mover: walks the steps of a move and the legs of
// each step, at most one multiplier operation per state. Uses fssm_pkg.
`default_nettype none

module fssm_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            out_busy,
	output fssm_pkg::ctrl_t ctrl
);

	fssm_pkg::state_t                 state_q;
	fssm_pkg::state_t                 state_d;
	logic [fssm_pkg::STEP_W-1:0]      step_q;
	logic [fssm_pkg::LEG_W-1:0]       leg_q;
	logic                             last_leg;
	logic                             last_step;

	assign last_leg  = (leg_q == fssm_pkg::LEG_W'(fssm_pkg::LEG_COUNT - 1));
	assign last_step = (step_q == fssm_pkg::STEP_W'(fssm_pkg::STEP_COUNT));

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			fssm_pkg::ST_IDLE: begin
				if (start) state_d = fssm_pkg::ST_HOLD_CAP;
			end
			fssm_pkg::ST_HOLD_CAP: state_d = fssm_pkg::ST_SQ_MUL;
			fssm_pkg::ST_SQ_MUL:   state_d = fssm_pkg::ST_NUM_MUL;
			fssm_pkg::ST_NUM_MUL:  state_d = fssm_pkg::ST_NUM_CAP;
			fssm_pkg::ST_NUM_CAP:  state_d = fssm_pkg::ST_DEL_MUL;
			fssm_pkg::ST_DEL_MUL:  state_d = fssm_pkg::ST_DEN_MUL;
			fssm_pkg::ST_DEN_MUL:  state_d = fssm_pkg::ST_ANG;
			fssm_pkg::ST_ANG:      state_d = fssm_pkg::ST_SPAN_MUL;
			fssm_pkg::ST_SPAN_MUL: state_d = fssm_pkg::ST_DIV_MUL;
			fssm_pkg::ST_DIV_MUL:  state_d = fssm_pkg::ST_PULSE;
			fssm_pkg::ST_PULSE:    state_d = fssm_pkg::ST_DUTY_MUL;
			fssm_pkg::ST_DUTY_MUL: state_d = fssm_pkg::ST_DUTY;
			fssm_pkg::ST_DUTY: begin
				state_d = last_leg ? fssm_pkg::ST_LOAD : fssm_pkg::ST_DEL_MUL;
			end
			fssm_pkg::ST_LOAD: begin
				if (!out_busy) begin
					state_d = last_step ? fssm_pkg::ST_IDLE : fssm_pkg::ST_SQ_MUL;
				end
			end
			default: state_d = fssm_pkg::ST_IDLE;
		endcase
	end

	// Control outputs.
	always_comb begin
		ctrl        = '0;
		ctrl.st     = state_q;
		ctrl.step   = step_q;
		ctrl.leg    = leg_q;
		ctrl.load   = (state_q == fssm_pkg::ST_LOAD) && !out_busy;
		ctrl.finish = (state_q == fssm_pkg::ST_LOAD) && !out_busy && last_step;
	end

	// State, step counter and leg counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fssm_pkg::ST_IDLE;
			step_q  <= '0;
			leg_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == fssm_pkg::ST_IDLE) begin
				step_q <= '0;
				leg_q  <= '0;
			end else if (state_q == fssm_pkg::ST_DUTY) begin
				leg_q <= last_leg ? '0 : leg_q + 1'b1;
			end else if ((state_q == fssm_pkg::ST_LOAD) && !out_busy && !last_step) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/four_servo_smoothstep_mover.sv
// Top level of the four-servo smoothstep mover: configuration registers,
// leg angle state, datapath around the shared multiplier and result register.
// Uses fssm_pkg, fssm_mul and fssm_ctrl.
`default_nettype none

// A move command (four target angles and a duration) yields STEP_COUNT+1
// results, one per easing step, each carrying the four servo duties, the hold
// time per step and a last-step flag. Every product goes through one shared
// multiplier under a sequencer, whose load state waits while results stall.
// in_stall is high while a move runs. The last result may still wait in the
// output register while the next command is taken. Duty limits apply at the
// next command after a write only if the user writes them between moves; the
// block itself does not enforce this.
module four_servo_smoothstep_mover (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write port
	input  logic                               cfg_wr_en,
	input  logic [fssm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [fssm_pkg::CFG_W-1:0]         cfg_data,
	// move command channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [fssm_pkg::ANGLE_W-1:0]       target_fl,
	input  logic [fssm_pkg::ANGLE_W-1:0]       target_fr,
	input  logic [fssm_pkg::ANGLE_W-1:0]       target_bl,
	input  logic [fssm_pkg::ANGLE_W-1:0]       target_br,
	input  logic [fssm_pkg::MS_W-1:0]          move_ms,
	// step result channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [fssm_pkg::DUTY_W-1:0]        duty_fl,
	output logic [fssm_pkg::DUTY_W-1:0]        duty_fr,
	output logic [fssm_pkg::DUTY_W-1:0]        duty_bl,
	output logic [fssm_pkg::DUTY_W-1:0]        duty_br,
	output logic [fssm_pkg::HOLD_W-1:0]        hold_ms,
	output logic [fssm_pkg::STEP_W-1:0]        step_index,
	output logic                               last_step
);

	fssm_pkg::ctrl_t                      ctrl;
	logic                                 start;
	logic                                 out_busy;

	logic [fssm_pkg::CFG_W-1:0]           min_q;
	logic [fssm_pkg::CFG_W-1:0]           max_q;
	logic [fssm_pkg::ANGLE_W-1:0]         ang_q [fssm_pkg::LEG_COUNT];
	logic [fssm_pkg::ANGLE_W-1:0]         tgt_q [fssm_pkg::LEG_COUNT];

	logic [fssm_pkg::MUL_A_W-1:0]         mul_a;
	logic [fssm_pkg::MUL_B_W-1:0]         mul_b;
	logic [fssm_pkg::MUL_P_W-1:0]         prod_q;

	logic [fssm_pkg::HOLD_W-1:0]          hold_q;
	logic [fssm_pkg::NUM_W-1:0]           num_q;
	logic                                 neg_q;
	logic [fssm_pkg::ANGLE_W-1:0]         deg_q;
	logic [fssm_pkg::PULSE_W-1:0]         pulse_q;
	logic [fssm_pkg::DUTY_W-1:0]          duty_q [fssm_pkg::LEG_COUNT];

	logic                                 out_valid_q;
	logic [fssm_pkg::DUTY_W-1:0]          out_duty_q [fssm_pkg::LEG_COUNT];
	logic [fssm_pkg::HOLD_W-1:0]          out_hold_q;
	logic [fssm_pkg::STEP_W-1:0]          out_step_q;
	logic                                 out_last_q;

	logic [fssm_pkg::ANGLE_W-1:0]         from_ang;
	logic signed [fssm_pkg::ANGLE_W:0]    delta;
	logic [fssm_pkg::ANGLE_W-1:0]         delta_mag;
	logic signed [fssm_pkg::CFG_W:0]      span;
	logic [fssm_pkg::CFG_W-1:0]           span_mag;
	logic signed [fssm_pkg::ANG_S_W-1:0]  ang_step;
	logic signed [fssm_pkg::ANG_S_W-1:0]  ang_servo;
	logic [fssm_pkg::ANGLE_W-1:0]         deg_d;
	logic signed [fssm_pkg::PULSE_S_W-1:0] pulse_step;
	logic signed [fssm_pkg::PULSE_S_W-1:0] pulse_off;
	logic [fssm_pkg::PULSE_W-1:0]         pulse_d;
	logic [fssm_pkg::ANGLE_W-1:0]         ang_q_off;

	assign in_stall = (ctrl.st != fssm_pkg::ST_IDLE);
	assign start    = in_valid && !in_stall;
	assign out_busy = out_valid_q && out_stall;

	fssm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.out_busy (out_busy),
		.ctrl     (ctrl)
	);

	fssm_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	// Configuration registers; an unknown index is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= fssm_pkg::CFG_W'(fssm_pkg::MIN_RESET);
			max_q <= fssm_pkg::CFG_W'(fssm_pkg::MAX_RESET);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				fssm_pkg::CFG_MIN_PULSE: min_q <= cfg_data;
				fssm_pkg::CFG_MAX_PULSE: max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Current leg angles; the targets take their place once the last step is loaded into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < fssm_pkg::LEG_COUNT; k++) begin
				ang_q[k] <= fssm_pkg::ANGLE_W'(fssm_pkg::ANGLE_RESET);
			end
		end else if (ctrl.finish) begin
			for (int k = 0; k < fssm_pkg::LEG_COUNT; k++) begin
				ang_q[k] <= tgt_q[k];
			end
		end
	end

	// Leg difference and signed pulse span.
	assign from_ang  = ang_q[ctrl.leg];
	assign delta     = $signed({1'b0, tgt_q[ctrl.leg]}) - $signed({1'b0, from_ang});
	assign delta_mag = delta[fssm_pkg::ANGLE_W] ? fssm_pkg::ANGLE_W'(-delta)
	                                            : delta[fssm_pkg::ANGLE_W-1:0];
	assign span      = $signed({1'b0, max_q}) - $signed({1'b0, min_q});
	assign span_mag  = span[fssm_pkg::CFG_W] ? fssm_pkg::CFG_W'(-span)
	                                         : span[fssm_pkg::CFG_W-1:0];

	// Multiplier operands for each sequencer state.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (ctrl.st)
			fssm_pkg::ST_IDLE: begin
				mul_a = fssm_pkg::MUL_A_W'(move_ms);
				mul_b = fssm_pkg::MUL_B_W'(fssm_pkg::RECIP_HOLD);
			end
			fssm_pkg::ST_SQ_MUL: begin
				mul_a = fssm_pkg::MUL_A_W'(ctrl.step);
				mul_b = fssm_pkg::MUL_B_W'(ctrl.step);
			end
			fssm_pkg::ST_NUM_MUL: begin
				mul_a = fssm_pkg::MUL_A_W'(prod_q[fssm_pkg::SQ_W-1:0]);
				mul_b = fssm_pkg::MUL_B_W'(3 * fssm_pkg::STEP_COUNT)
				      - (fssm_pkg::MUL_B_W'(ctrl.step) << 1);
			end
			fssm_pkg::ST_DEL_MUL: begin
				mul_a = fssm_pkg::MUL_A_W'(delta_mag);
				mul_b = fssm_pkg::MUL_B_W'(num_q);
			end
			fssm_pkg::ST_DEN_MUL: begin
				mul_a = fssm_pkg::MUL_A_W'(prod_q[fssm_pkg::MAG_W-1:0]);
				mul_b = fssm_pkg::MUL_B_W'(fssm_pkg::RECIP_DEN);
			end
			fssm_pkg::ST_SPAN_MUL: begin
				mul_a = fssm_pkg::MUL_A_W'(deg_q);
				mul_b = fssm_pkg::MUL_B_W'(span_mag);
			end
			fssm_pkg::ST_DIV_MUL: begin
				mul_a = fssm_pkg::MUL_A_W'(prod_q[fssm_pkg::SCALED_W-1:0]);
				mul_b = fssm_pkg::MUL_B_W'(fssm_pkg::RECIP_ANG);
			end
			fssm_pkg::ST_DUTY_MUL: begin
				mul_a = fssm_pkg::MUL_A_W'(pulse_q);
				mul_b = fssm_pkg::MUL_B_W'(fssm_pkg::RECIP_DUTY);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Eased angle of this leg, mirrored where needed, clamped to the servo range.
	assign ang_q_off = prod_q[fssm_pkg::DEN_SHIFT +: fssm_pkg::ANGLE_W];
	always_comb begin
		ang_step = $signed({3'b000, from_ang})
		         + (neg_q ? -$signed({3'b000, ang_q_off}) : $signed({3'b000, ang_q_off}));
		if ((ctrl.leg == fssm_pkg::LEG_FR) || (ctrl.leg == fssm_pkg::LEG_BL)) begin
			ang_servo = fssm_pkg::ANG_S_W'(fssm_pkg::ANGLE_MAX) - ang_step;
		end else begin
			ang_servo = ang_step;
		end
		if (ang_servo < 0) begin
			deg_d = '0;
		end else if (ang_servo > fssm_pkg::ANG_S_W'(fssm_pkg::ANGLE_MAX)) begin
			deg_d = fssm_pkg::ANGLE_W'(fssm_pkg::ANGLE_MAX);
		end else begin
			deg_d = ang_servo[fssm_pkg::ANGLE_W-1:0];
		end
	end

	// Pulse width from the angle, saturated to the PWM period.
	always_comb begin
		pulse_off  = $signed({3'b000, prod_q[fssm_pkg::ANG_SHIFT +: fssm_pkg::PULSE_W]});
		pulse_step = $signed({3'b000, min_q})
		           + (span[fssm_pkg::CFG_W] ? -pulse_off : pulse_off);
		if (pulse_step < 0) begin
			pulse_d = '0;
		end else if (pulse_step > fssm_pkg::PULSE_S_W'(fssm_pkg::PERIOD_US)) begin
			pulse_d = fssm_pkg::PULSE_W'(fssm_pkg::PERIOD_US);
		end else begin
			pulse_d = pulse_step[fssm_pkg::PULSE_W-1:0];
		end
	end

	// Working registers, each written in its own sequencer state.
	always_ff @(posedge clk) begin
		if (start) begin
			tgt_q[0] <= target_fl;
			tgt_q[1] <= target_fr;
			tgt_q[2] <= target_bl;
			tgt_q[3] <= target_br;
		end
		if (ctrl.st == fssm_pkg::ST_HOLD_CAP) begin
			hold_q <= prod_q[fssm_pkg::HOLD_SHIFT +: fssm_pkg::HOLD_W];
		end
		if (ctrl.st == fssm_pkg::ST_NUM_CAP) begin
			num_q <= prod_q[fssm_pkg::NUM_W-1:0];
		end
		if (ctrl.st == fssm_pkg::ST_DEL_MUL) begin
			neg_q <= delta[fssm_pkg::ANGLE_W];
		end
		if (ctrl.st == fssm_pkg::ST_ANG) begin
			deg_q <= deg_d;
		end
		if (ctrl.st == fssm_pkg::ST_PULSE) begin
			pulse_q <= pulse_d;
		end
		if (ctrl.st == fssm_pkg::ST_DUTY) begin
			duty_q[ctrl.leg] <= prod_q[fssm_pkg::DUTY_SHIFT +: fssm_pkg::DUTY_W];
		end
	end

	// Result register: loaded when empty or when its content transfers this cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			for (int k = 0; k < fssm_pkg::LEG_COUNT; k++) begin
				out_duty_q[k] <= duty_q[k];
			end
			out_hold_q <= hold_q;
			out_step_q <= ctrl.step;
			out_last_q <= ctrl.finish;
		end
	end

	assign out_valid  = out_valid_q;
	assign duty_fl    = out_duty_q[0];
	assign duty_fr    = out_duty_q[1];
	assign duty_bl    = out_duty_q[2];
	assign duty_br    = out_duty_q[3];
	assign hold_ms    = out_hold_q;
	assign step_index = out_step_q;
	assign last_step  = out_last_q;

endmodule

`default_nettype wire

>>> rtl/core/fssm_checker.sv
// Port-level checks for the four-servo smoothstep mover, bound to its top level.
// Uses fssm_pkg and four_servo_smoothstep_mover.
`default_nettype none

module fssm_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic [fssm_pkg::STEP_W-1:0]       step_index,
	input  logic                              last_step
);

	// The last-step flag marks exactly the final step number.
	a_last_matches_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_step == (step_index == fssm_pkg::STEP_W'(fssm_pkg::STEP_COUNT))))
		else $error("last_step does not match step_index");

	// A command transfer starts a move, so the next command must wait.
	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("command taken while a move starts");

	// While an earlier step of a move is shown, the move is still running.
	a_busy_mid_move: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last_step) |-> in_stall)
		else $error("command channel open in the middle of a move");

	// A stalled result stays in place.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(step_index)))
		else $error("stalled result changed");

endmodule

bind four_servo_smoothstep_mover fssm_checker u_fssm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.step_index (step_index),
	.last_step  (last_step)
);

`default_nettype wire
